/* design/disjoint_set_union_engine_assert.svh */
// ----------------------------------------------------------------------------
// disjoint_set_union_engine_assert.svh
// assertion macros for the disjoint-set union engine datapath
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_ENGINE_ASSERT_SVH
`define DISJOINT_SET_UNION_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DSU_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DSU_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/dsu_pkg.sv */
// ----------------------------------------------------------------------------
// dsu_pkg
// types and constants shared by the disjoint-set union engine
// ----------------------------------------------------------------------------
package dsu_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int IDX_W            = 10;
	localparam int CNT_W            = 11;

	localparam logic CMD_JOIN = 1'b0;

	typedef struct packed {
		logic             command;
		logic [IDX_W-1:0] first_element;
		logic [IDX_W-1:0] second_element;
	} dsu_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_root;
		logic             merged;
		logic             same_set;
		logic [CNT_W-1:0] set_size;
		logic [CNT_W-1:0] sets_remaining;
		logic             index_error;
	} dsu_rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_LOAD,
		OP_WALK,
		OP_COMP,
		OP_SIZE_A,
		OP_SIZE_B,
		OP_FINISH,
		OP_ERR
	} dsu_op_t;

	typedef struct packed {
		dsu_op_t op;
		logic    sel_b;
	} dsu_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic index_err;
		logic root_hit;
		logic path_done;
		logic rsp_busy;
	} dsu_status_t;

endpackage

/* design/dsu_ctrl.sv */
// ----------------------------------------------------------------------------
// dsu_ctrl
// sequencer for clearing, root walks, path compression and the join step
// ----------------------------------------------------------------------------
module dsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                cfg_we,
	input  dsu_pkg::dsu_status_t status,
	output dsu_pkg::dsu_cmd_t    cmd
);
	import dsu_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_COMP,
		S_SIZE_B,
		S_FINISH,
		S_ERR
	} state_t;

	state_t state_q, state_n;
	logic   phase_q, phase_n;

	assign req_ready = (state_q == S_IDLE) && !cfg_we;

	always_comb begin
		state_n   = state_q;
		phase_n   = phase_q;
		cmd.op    = OP_NONE;
		cmd.sel_b = phase_q;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (status.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid && req_ready) begin
					cmd.op  = OP_ACCEPT;
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.op    = OP_LOAD;
				cmd.sel_b = 1'b0;
				phase_n   = 1'b0;
				state_n   = status.index_err ? S_ERR : S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (status.root_hit) begin
					state_n = S_COMP;
				end
			end
			S_COMP: begin
				if (!status.path_done) begin
					cmd.op = OP_COMP;
				end else if (!phase_q) begin
					cmd.op    = OP_LOAD;
					cmd.sel_b = 1'b1;
					phase_n   = 1'b1;
					state_n   = S_WALK;
				end else begin
					cmd.op  = OP_SIZE_A;
					state_n = S_SIZE_B;
				end
			end
			S_SIZE_B: begin
				cmd.op  = OP_SIZE_B;
				state_n = S_FINISH;
			end
			S_FINISH: begin
				if (!status.rsp_busy) begin
					cmd.op  = OP_FINISH;
					state_n = S_IDLE;
				end
			end
			S_ERR: begin
				if (!status.rsp_busy) begin
					cmd.op  = OP_ERR;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_CLEAR;
			end
		endcase
		if (cfg_we) begin
			state_n = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
		end
	end

endmodule

/* design/dsu_datapath.sv */
// ----------------------------------------------------------------------------
// dsu_datapath
// parent and size tables, walk and compression registers, result register
// ----------------------------------------------------------------------------
`include "disjoint_set_union_engine_assert.svh"

module dsu_datapath #(
	parameter int MAX_ELEMENTS = dsu_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dsu_pkg::dsu_cmd_t          cmd,
	output dsu_pkg::dsu_status_t       status,
	input  dsu_pkg::dsu_req_t          req,
	input  logic                       cfg_we,
	input  logic [dsu_pkg::CNT_W-1:0]  cfg_data,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output dsu_pkg::dsu_rsp_t          rsp
);
	import dsu_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int SW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [AW-1:0]    LAST_ADDR   = AW'(MAX_ELEMENTS - 1);
	localparam logic [CNT_W-1:0] RESET_COUNT =
		(MAX_ELEMENTS < 1024) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(1024);

	logic [AW-1:0] parent_mem [MAX_ELEMENTS];
	logic [SW-1:0] size_mem   [MAX_ELEMENTS];

	logic             command_q;
	logic [IDX_W-1:0] first_q, second_q;
	logic [AW-1:0]    cur_q, top_q, ra_q, rb_q, clr_q, par_rd_q;
	logic [SW-1:0]    size_rd_q, sza_q;
	logic [CNT_W-1:0] count_q, join_q;
	logic             rsp_valid_q;
	dsu_rsp_t         rsp_q;

	logic [AW-1:0]    first_addr, second_addr, src_addr;
	logic [AW-1:0]    winner, loser;
	logic [AW-1:0]    par_raddr, par_waddr, par_wdata, size_raddr, size_waddr;
	logic [SW-1:0]    size_sum, size_wdata;
	logic [CNT_W-1:0] cfg_count;
	logic             root_hit, path_done, same, do_join, b_wins;
	logic             par_we, size_we, size_re;

	assign first_addr  = AW'(first_q);
	assign second_addr = AW'(second_q);
	assign src_addr    = cmd.sel_b ? second_addr : first_addr;
	assign root_hit    = (par_rd_q == cur_q);
	assign path_done   = (cur_q == top_q);
	assign same        = (ra_q == rb_q);
	assign do_join     = (command_q == CMD_JOIN) && !same;
	assign b_wins      = (sza_q < size_rd_q);
	assign winner      = b_wins ? rb_q : ra_q;
	assign loser       = b_wins ? ra_q : rb_q;
	assign size_sum    = sza_q + size_rd_q;

	assign cfg_count = (cfg_data == '0) ? CNT_W'(1) :
		((32'(cfg_data) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : cfg_data);

	assign status.clr_last  = (clr_q == LAST_ADDR);
	assign status.index_err = (CNT_W'(first_q) >= count_q) || (CNT_W'(second_q) >= count_q);
	assign status.root_hit  = root_hit;
	assign status.path_done = path_done;
	assign status.rsp_busy  = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		par_raddr  = cur_q;
		par_we     = 1'b0;
		par_waddr  = clr_q;
		par_wdata  = clr_q;
		size_we    = 1'b0;
		size_re    = 1'b0;
		size_raddr = ra_q;
		size_waddr = clr_q;
		size_wdata = SW'(1);
		case (cmd.op)
			OP_CLEAR: begin
				par_we  = 1'b1;
				size_we = 1'b1;
			end
			OP_LOAD: begin
				par_raddr = src_addr;
			end
			OP_WALK: begin
				par_raddr = root_hit ? src_addr : par_rd_q;
			end
			OP_COMP: begin
				par_raddr = par_rd_q;
				par_we    = !path_done;
				par_waddr = cur_q;
				par_wdata = top_q;
			end
			OP_SIZE_A: begin
				size_re = 1'b1;
			end
			OP_SIZE_B: begin
				size_re    = 1'b1;
				size_raddr = rb_q;
			end
			OP_FINISH: begin
				par_we     = do_join;
				par_waddr  = loser;
				par_wdata  = winner;
				size_we    = do_join;
				size_waddr = winner;
				size_wdata = size_sum;
			end
			default: begin
				par_raddr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			parent_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= parent_mem[par_raddr];
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		if (size_re) begin
			size_rd_q <= size_mem[size_raddr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				command_q <= req.command;
				first_q   <= req.first_element;
				second_q  <= req.second_element;
			end
			OP_LOAD: begin
				cur_q <= src_addr;
			end
			OP_WALK: begin
				if (root_hit) begin
					top_q <= cur_q;
					cur_q <= src_addr;
					if (cmd.sel_b) begin
						rb_q <= cur_q;
					end else begin
						ra_q <= cur_q;
					end
				end else begin
					cur_q <= par_rd_q;
				end
			end
			OP_COMP: begin
				if (!path_done) begin
					cur_q <= par_rd_q;
				end
			end
			OP_SIZE_B: begin
				sza_q <= size_rd_q;
			end
			OP_FINISH: begin
				rsp_q.result_root    <= IDX_W'(do_join ? winner : ra_q);
				rsp_q.merged         <= do_join;
				rsp_q.same_set       <= same;
				rsp_q.set_size       <= CNT_W'(do_join ? size_sum : sza_q);
				rsp_q.sets_remaining <= count_q - join_q - CNT_W'(do_join);
				rsp_q.index_error    <= 1'b0;
			end
			OP_ERR: begin
				rsp_q.result_root    <= '0;
				rsp_q.merged         <= 1'b0;
				rsp_q.same_set       <= 1'b0;
				rsp_q.set_size       <= '0;
				rsp_q.sets_remaining <= count_q - join_q;
				rsp_q.index_error    <= 1'b1;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= RESET_COUNT;
			join_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_count;
				join_q  <= '0;
				clr_q   <= '0;
			end else begin
				if (cmd.op == OP_CLEAR) begin
					clr_q <= status.clr_last ? '0 : clr_q + 1'b1;
				end
				if (cmd.op == OP_FINISH && do_join) begin
					join_q <= join_q + 1'b1;
				end
			end
			if (cmd.op == OP_FINISH || cmd.op == OP_ERR) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`DSU_ASSERT_IMP(a_sets_nonzero, rsp_valid_q, rsp_q.sets_remaining != '0, "set count hit zero")
	`DSU_ASSERT_IMP(a_merge_excl, rsp_valid_q, !(rsp_q.merged && rsp_q.same_set), "merged with same set")
	`DSU_ASSERT_IMP(a_err_clean, rsp_valid_q && rsp_q.index_error, !rsp_q.merged && !rsp_q.same_set && (rsp_q.set_size == '0), "error item carries data")
	`DSU_ASSERT_NXT(a_join_count, (cmd.op == OP_FINISH) && do_join && !cfg_we, join_q == $past(join_q) + 1'b1, "join count not advanced")

endmodule

/* design/disjoint_set_union_engine.sv */
// ----------------------------------------------------------------------------
// disjoint_set_union_engine
// union-find over a fixed element table, union by size, full path compression
// ----------------------------------------------------------------------------
// req channel (valid/ready) carries command, first and second element; one
// item at a time is worked on, req_ready is high only while the engine idles.
// rsp channel (valid/ready) returns one item per request from a result
// register; a new request is taken while that result still waits.
// the work for a request grows with La and Lb, the parent-chain lengths
// of the two elements; the single read port of the parent table walks one
// link per cycle for the root search and again for the compression pass.
// an out-of-range index skips the walks and returns an error item. the next
// request can be accepted as soon as the result is written, in the cycle in
// which rsp_valid rises. a stalled receiver holds the finished item in the
// result register and the engine waits before writing the next one.
// after reset, and after every element_count write on cfg_we/cfg_data, a
// clearing pass over all MAX_ELEMENTS entries rebuilds the singleton table;
// no item is accepted during it.
// ----------------------------------------------------------------------------
module disjoint_set_union_engine #(
	parameter int MAX_ELEMENTS = dsu_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  dsu_pkg::dsu_req_t         req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output dsu_pkg::dsu_rsp_t         rsp,
	input  logic                      cfg_we,
	input  logic [dsu_pkg::CNT_W-1:0] cfg_data
);
	import dsu_pkg::*;

	dsu_cmd_t    cmd;
	dsu_status_t status;

	dsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cfg_we    (cfg_we),
		.status    (status),
		.cmd       (cmd)
	);

	dsu_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
